// ===== rtl/ffsd_pkg.sv =====
// shared types and codes of the four-finger swipe detector
`timescale 1ns / 1ps

package ffsd_pkg;

  // touch event codes
  localparam logic [2:0] OP_DOWN   = 3'd0;
  localparam logic [2:0] OP_MOTION = 3'd1;
  localparam logic [2:0] OP_UP     = 3'd2;
  localparam logic [2:0] OP_FRAME  = 3'd3;
  localparam logic [2:0] OP_CANCEL = 3'd4;
  localparam logic [2:0] OP_RESET  = 3'd5;

  // result status codes
  localparam logic [2:0] ST_IGNORE    = 3'd0;
  localparam logic [2:0] ST_BEGIN     = 3'd1;
  localparam logic [2:0] ST_UPDATE    = 3'd2;
  localparam logic [2:0] ST_FINISHED  = 3'd3;
  localparam logic [2:0] ST_CANCELLED = 3'd4;

  // direction codes
  localparam logic [2:0] DIR_NONE  = 3'd0;
  localparam logic [2:0] DIR_UP    = 3'd1;
  localparam logic [2:0] DIR_DOWN  = 3'd2;
  localparam logic [2:0] DIR_LEFT  = 3'd3;
  localparam logic [2:0] DIR_RIGHT = 3'd4;

  localparam logic [15:0] THRESHOLD_RESET = 16'd400;
  localparam logic [3:0]  COUNT_MAX       = 4'd15;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
  } point_t;

  typedef struct packed {
    logic [2:0]  operation;
    logic [1:0]  slot;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
  } in_word_t;

  typedef struct packed {
    logic [2:0] status;
    logic [2:0] last_dir;
    logic [2:0] total_dir;
  } out_word_t;

endpackage

// ===== rtl/ffsd_motion.sv =====
// centroid movement between two point sets: l1 test and dominant direction
`timescale 1ns / 1ps

module ffsd_motion
  import ffsd_pkg::*;
#(
  parameter int FINGERS = 4
) (
  input  point_t [FINGERS-1:0] to_i,
  input  point_t [FINGERS-1:0] from_i,
  input  logic [15:0]          thr_i,
  output logic                 moved_o,
  output logic [2:0]           dir_o
);

  localparam int SumW = 16 + $clog2(FINGERS);

  logic [SumW-1:0] sum_tx, sum_ty, sum_fx, sum_fy;
  logic signed [SumW:0] dx, dy;
  logic [SumW-1:0] abs_x, abs_y;
  logic [SumW:0] l1, limit;

  always_comb begin
    sum_tx = '0;
    sum_ty = '0;
    sum_fx = '0;
    sum_fy = '0;
    for (int i = 0; i < FINGERS; i++) begin
      sum_tx = sum_tx + SumW'(to_i[i].x);
      sum_ty = sum_ty + SumW'(to_i[i].y);
      sum_fx = sum_fx + SumW'(from_i[i].x);
      sum_fy = sum_fy + SumW'(from_i[i].y);
    end
  end

  assign dx = $signed({1'b0, sum_tx}) - $signed({1'b0, sum_fx});
  assign dy = $signed({1'b0, sum_ty}) - $signed({1'b0, sum_fy});

  assign abs_x = dx[SumW] ? SumW'(-dx) : SumW'(dx);
  assign abs_y = dy[SumW] ? SumW'(-dy) : SumW'(dy);

  assign l1    = {1'b0, abs_x} + {1'b0, abs_y};
  assign limit = (SumW+1)'(thr_i) * (SumW+1)'(FINGERS);

  assign moved_o = (l1 >= limit);

  // ties go vertical
  always_comb begin
    if (abs_x > abs_y) begin
      dir_o = (!dx[SumW] && (dx != '0)) ? DIR_RIGHT : DIR_LEFT;
    end else begin
      dir_o = (!dy[SumW] && (dy != '0)) ? DIR_DOWN : DIR_UP;
    end
  end

endmodule

// ===== rtl/ffsd_core.sv =====
// gesture state registers and next-state logic for one word per step
`timescale 1ns / 1ps

module ffsd_core
  import ffsd_pkg::*;
#(
  parameter int FINGERS = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_i,
  input  in_word_t  word_i,
  input  logic [15:0] thr_i,
  output out_word_t result_o
);

  logic [3:0] count_q, count_d;
  logic       cancelled_q, cancelled_d;
  logic       started_q, started_d;
  logic [2:0] last_dir_q, last_dir_d;
  point_t [FINGERS-1:0] start_q, start_d;
  point_t [FINGERS-1:0] last_q, last_d;
  point_t [FINGERS-1:0] cur_q, cur_d;

  logic       frame_moved, total_moved;
  logic [2:0] frame_dir, total_dir;
  logic [2:0] status;
  logic [3:0] count_inc, count_dec;
  logic       slot_ok;
  point_t     pos;

  // frame test uses the registered points, total test the updated ones
  ffsd_motion #(.FINGERS(FINGERS)) u_frame (
    .to_i    (cur_q),
    .from_i  (last_q),
    .thr_i   (thr_i),
    .moved_o (frame_moved),
    .dir_o   (frame_dir)
  );

  ffsd_motion #(.FINGERS(FINGERS)) u_total (
    .to_i    (cur_d),
    .from_i  (start_d),
    .thr_i   (thr_i),
    .moved_o (total_moved),
    .dir_o   (total_dir)
  );

  assign count_inc = (count_q == COUNT_MAX) ? COUNT_MAX : count_q + 4'd1;
  assign count_dec = (count_q == 4'd0) ? 4'd0 : count_q - 4'd1;
  assign slot_ok   = (int'(word_i.slot) < FINGERS);
  assign pos       = '{x: word_i.pos_x, y: word_i.pos_y};

  always_comb begin
    count_d     = count_q;
    cancelled_d = cancelled_q;
    started_d   = started_q;
    last_dir_d  = last_dir_q;
    start_d     = start_q;
    last_d      = last_q;
    cur_d       = cur_q;
    status      = ST_IGNORE;

    case (word_i.operation)
      OP_DOWN: begin
        count_d = count_inc;
        if (!cancelled_q) begin
          if (count_inc <= 4'(FINGERS)) begin
            for (int i = 0; i < FINGERS; i++) begin
              if (slot_ok && (int'(word_i.slot) == i)) begin
                start_d[i] = pos;
              end
            end
          end
          if (count_inc == 4'(FINGERS)) begin
            started_d = 1'b1;
            last_d    = start_d;
            cur_d     = start_d;
            status    = ST_BEGIN;
          end else if (count_inc > 4'(FINGERS)) begin
            cancelled_d = 1'b1;
            status      = ST_CANCELLED;
          end
        end
      end
      OP_MOTION: begin
        if (!cancelled_q) begin
          for (int i = 0; i < FINGERS; i++) begin
            if (slot_ok && (int'(word_i.slot) == i)) begin
              cur_d[i] = pos;
              if (!started_q) begin
                start_d[i] = pos;
              end
            end
          end
        end
      end
      OP_UP: begin
        count_d = count_dec;
        if (count_dec == 4'd0) begin
          if (!cancelled_q && started_q && (last_dir_q != DIR_NONE)) begin
            status = ST_FINISHED;
          end else begin
            cancelled_d = 1'b0;
            started_d   = 1'b0;
            last_dir_d  = DIR_NONE;
            start_d     = '0;
            last_d      = '0;
            cur_d       = '0;
          end
        end
      end
      OP_FRAME: begin
        if (!cancelled_q && started_q && (count_q == 4'(FINGERS)) && frame_moved) begin
          last_d     = cur_q;
          last_dir_d = frame_dir;
          status     = ST_UPDATE;
        end
      end
      OP_CANCEL: begin
        cancelled_d = 1'b1;
        status      = ST_CANCELLED;
      end
      OP_RESET: begin
        cancelled_d = 1'b0;
        started_d   = 1'b0;
        last_dir_d  = DIR_NONE;
        start_d     = '0;
        last_d      = '0;
        cur_d       = '0;
      end
      default: begin
      end
    endcase
  end

  assign result_o = '{status:    status,
                      last_dir:  last_dir_d,
                      total_dir: total_moved ? total_dir : DIR_NONE};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cancelled_q <= 1'b0;
      started_q   <= 1'b0;
      last_dir_q  <= DIR_NONE;
      start_q     <= '0;
      last_q      <= '0;
      cur_q       <= '0;
    end else if (step_i) begin
      count_q     <= count_d;
      cancelled_q <= cancelled_d;
      started_q   <= started_d;
      last_dir_q  <= last_dir_d;
      start_q     <= start_d;
      last_q      <= last_d;
      cur_q       <= cur_d;
    end
  end

endmodule

// ===== rtl/four_finger_swipe_detector.sv =====
// top level of the four-finger swipe detector: word registers and threshold
`timescale 1ns / 1ps
// an accepted word waits in the input register until the result register can take
// it, and its result word is then registered there; an output stall keeps it waiting
// throughput: one word per cycle while the output side does not stall
// reset: asynchronous, clears all gesture state and empties both word registers,
// threshold returns to 400

module four_finger_swipe_detector
  import ffsd_pkg::*;
#(
  parameter int FINGERS = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input event words
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_word_t    in_word_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_word_t   out_word_o,
  // threshold register
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_data_i
);

  logic        in_valid_q, in_valid_d;
  in_word_t    in_word_q;
  logic        out_valid_q, out_valid_d;
  out_word_t   out_word_q;
  logic [15:0] thr_q;

  logic      advance;
  logic      step;
  logic      in_take;
  out_word_t result;

  // the result register frees up when empty or when its word leaves now
  assign advance = !out_valid_q || !out_stall_i;
  // the held input word is processed whenever the result register can take it
  assign step    = in_valid_q && advance;
  // input register holds a word that cannot move on yet
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  ffsd_core #(.FINGERS(FINGERS)) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .word_i   (in_word_q),
    .thr_i    (thr_q),
    .result_o (result)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  assign out_valid_d = advance ? step : out_valid_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      thr_q       <= THRESHOLD_RESET;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        thr_q <= cfg_data_i;
      end
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_word_q <= in_word_i;
    end
    if (step) begin
      out_word_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

endmodule

// ===== rtl/ffsd_checker.sv =====
// port-level checks for the four-finger swipe detector, bound to the top level
`timescale 1ns / 1ps

module ffsd_port_checks
  import ffsd_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_word_t out_word_o
);

  // a stalled result word stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_word_o))
    else $error("stalled result word changed");

  // with the output side free the input side never stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_stall_i |-> !in_stall_o)
    else $error("input stalled while output free");

  // an update always carries a real direction
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status == ST_UPDATE) |-> out_word_o.last_dir != DIR_NONE)
    else $error("update without direction");

  // a finished gesture has moved at least once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.status == ST_FINISHED) |-> out_word_o.last_dir != DIR_NONE)
    else $error("finished without direction");

endmodule

bind four_finger_swipe_detector ffsd_port_checks u_ffsd_port_checks (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
